// File: rtl/core/morse_keyer_decoder_defines.svh
// ----------------------------------------------------------------------------
// morse keyer decoder assertion macros
// ----------------------------------------------------------------------------
`ifndef MORSE_KEYER_DECODER_DEFINES_SVH
`define MORSE_KEYER_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MKD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mkd assertion failed");

// next-cycle implication, checked outside reset
`define MKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mkd assertion failed");

`endif

// File: rtl/core/mkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkd_pkg
// shared types and constants of the morse keyer decoder
// ----------------------------------------------------------------------------
package mkd_pkg;

    localparam int LETTER_COUNT = 26;
    localparam int LETTER_W     = 5;
    localparam int DUR_W        = 16;
    localparam int UNIT_W       = 13;

    localparam logic [UNIT_W-1:0] UNIT_RESET = 13'd200;
    localparam logic              OP_GAP     = 1'b1;

    typedef enum logic [2:0] {
        EV_CONTINUE     = 3'd0,
        EV_LETTER       = 3'd1,
        EV_LETTER_SPACE = 3'd2,
        EV_NOT_FOUND    = 3'd3,
        EV_TOO_LONG     = 3'd4,
        EV_EXTRA_SPACE  = 3'd5
    } t_event;

    // element count and dash pattern (element i is bit i, dash = 1) of A..Z
    localparam logic [2:0] CODE_LEN [LETTER_COUNT] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [3:0] CODE_BITS [LETTER_COUNT] = '{
        4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
        4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
    };

    typedef struct packed {
        logic                found;
        logic [LETTER_W-1:0] index;
    } t_lookup;

endpackage

// File: rtl/core/mkd_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkd_lookup
// matches the held symbol against the letters A-Z
// ----------------------------------------------------------------------------
module mkd_lookup
    import mkd_pkg::*;
#(
    parameter int PAT_W = 4,
    parameter int CNT_W = 3
) (
    input  logic [CNT_W-1:0] i_count,
    input  logic [PAT_W-1:0] i_pattern,
    output t_lookup          o_result
);

    always_comb begin
        o_result = '0;
        // letter codes are unique, the scan order only settles the mux
        for (int i = LETTER_COUNT - 1; i >= 0; i--) begin
            if (i_count == CNT_W'(CODE_LEN[i]) && i_pattern == PAT_W'(CODE_BITS[i])) begin
                o_result.found = 1'b1;
                o_result.index = LETTER_W'(i);
            end
        end
    end

endmodule

// File: rtl/core/morse_keyer_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_keyer_decoder
// turns timed key press and gap beats into decoded letters and spacing events
// ----------------------------------------------------------------------------
// usage:
//   input channel: i_in_valid / o_in_stall with i_operation (0 press, 1 gap)
//   and i_duration_ms. a press beat gives no result, a gap beat gives one.
//   output channel: o_out_valid / i_out_stall with o_event_code and
//   o_letter_index (zero unless a letter is reported).
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_data, the unit length
//   in ms; o_cfg_ready is always high, write only while the block is idle.
//   the dot/dash and gap thresholds are derived from it at write time.
// timing:
//   a beat sits in the input register and is decoded into the result register.
//   one beat per cycle is taken unless a gap beat waits on a stalled receiver;
//   the input register plus result register pair sets that figure.
// reset and stall:
//   reset empties both registers, clears the symbol, sets the word start flag
//   and loads a unit length of 200 ms. while the receiver stalls the result
//   holds; press beats still drain, and a gap beat waits in the input register,
//   which then stalls the sender.
// ----------------------------------------------------------------------------
`include "morse_keyer_decoder_defines.svh"

module morse_keyer_decoder
    import mkd_pkg::*;
#(
    parameter int MAX_ELEMENTS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [DUR_W-1:0]    i_duration_ms,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_event_code,
    output logic [LETTER_W-1:0] o_letter_index,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [UNIT_W-1:0]   i_cfg_data
);

    localparam int PAT_W = MAX_ELEMENTS;
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 2);

    // thresholds
    logic [DUR_W-1:0] r_half, r_three, r_seven;
    // input register
    logic             r_in_vld;
    logic             r_in_op;
    logic [DUR_W-1:0] r_in_dur;
    // symbol state
    logic [PAT_W-1:0] r_pattern, n_pattern;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_word_start, n_word_start;
    // result register
    logic                r_out_vld;
    t_event              r_out_code, n_code;
    logic [LETTER_W-1:0] r_out_letter, n_letter;

    t_lookup lk;
    logic    advance;
    logic    out_free;
    logic    in_accept;
    logic    is_gap;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= DUR_W'(UNIT_RESET >> 1);
            r_three <= DUR_W'(UNIT_RESET) + DUR_W'({UNIT_RESET, 1'b0});
            r_seven <= DUR_W'({UNIT_RESET, 3'b000}) - DUR_W'(UNIT_RESET);
        end else if (i_cfg_valid) begin
            r_half  <= DUR_W'(i_cfg_data >> 1);
            r_three <= DUR_W'(i_cfg_data) + DUR_W'({i_cfg_data, 1'b0});
            r_seven <= DUR_W'({i_cfg_data, 3'b000}) - DUR_W'(i_cfg_data);
        end
    end

    mkd_lookup #(
        .PAT_W (PAT_W),
        .CNT_W (CNT_W)
    ) u_lookup (
        .i_count   (r_count),
        .i_pattern (r_pattern),
        .o_result  (lk)
    );

    assign is_gap     = (r_in_op == OP_GAP);
    assign out_free   = !r_out_vld || !i_out_stall;
    assign advance    = r_in_vld && (!is_gap || out_free);
    assign o_in_stall = r_in_vld && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_pattern    = r_pattern;
        n_count      = r_count;
        n_word_start = r_word_start;
        n_code       = EV_CONTINUE;
        n_letter     = '0;
        if (!is_gap) begin
            if (r_in_dur >= r_half) begin
                if (r_count < CNT_W'(MAX_ELEMENTS)) begin
                    if (r_in_dur >= r_three) begin
                        n_pattern = r_pattern | (PAT_W'(1) << r_count);
                    end
                    n_count = r_count + CNT_W'(1);
                end else begin
                    n_count = CNT_W'(MAX_ELEMENTS + 1);
                end
            end
        end else if (r_in_dur < r_three) begin
            if (r_count >= CNT_W'(MAX_ELEMENTS)) begin
                n_pattern = '0;
                n_count   = '0;
                n_code    = EV_TOO_LONG;
            end
        end else begin
            n_pattern = '0;
            n_count   = '0;
            if (r_in_dur >= r_seven && r_word_start) begin
                n_code = EV_EXTRA_SPACE;
            end else if (!lk.found) begin
                n_code = EV_NOT_FOUND;
            end else if (r_in_dur < r_seven) begin
                n_code       = EV_LETTER;
                n_letter     = lk.index;
                n_word_start = 1'b0;
            end else begin
                n_code       = EV_LETTER_SPACE;
                n_letter     = lk.index;
                n_word_start = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_pattern    <= '0;
            r_count      <= '0;
            r_word_start <= 1'b1;
        end else begin
            if (in_accept) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_pattern    <= n_pattern;
                r_count      <= n_count;
                r_word_start <= n_word_start;
            end
            if (advance && is_gap) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op  <= i_operation;
            r_in_dur <= i_duration_ms;
        end
        if (advance && is_gap) begin
            r_out_code   <= n_code;
            r_out_letter <= n_letter;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_event_code   = r_out_code;
    assign o_letter_index = r_out_letter;

    `MKD_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(MAX_ELEMENTS + 1))
    `MKD_ASSERT_NOW(a_letter_only_on_match, i_clk, i_rst_n,
        r_out_vld && r_out_code != EV_LETTER && r_out_code != EV_LETTER_SPACE,
        r_out_letter == '0)
    `MKD_ASSERT_NOW(a_letter_in_range, i_clk, i_rst_n, r_out_vld,
        r_out_letter < LETTER_W'(LETTER_COUNT))
    `MKD_ASSERT_NEXT(a_long_gap_clears, i_clk, i_rst_n,
        advance && is_gap && r_in_dur >= r_three,
        r_count == '0 && r_pattern == '0)
    `MKD_ASSERT_NOW(a_stall_needs_item, i_clk, i_rst_n, !r_in_vld, !o_in_stall)

endmodule
